@@ src/cbse_pkg.sv @@
// ----------------------------------------------------------------------------
// cbse_pkg: shared types and helpers for the cubic Bezier spline evaluator
// Holds table sizes, coordinate widths, command/status codes, the sequencer
// states and the saturation helpers used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cbse_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_W    = 32;
  localparam int FRAC       = 16;
  localparam int ONE        = 65536;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int T_W        = FRAC + 1;          // local t, 0..65536
  localparam int SF_W       = T_W + CNT_W;       // t scaled by count-1
  localparam int WT_W       = FRAC + 2;          // widest weight (3*v^2)
  localparam int PROD_W     = COORD_W + 1 + WT_W + 1;
  localparam int ACC_W      = COORD_W + WT_W + 6;
  localparam int VEC_W      = 3 * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_APPEND  = 3'd1,
    CMD_SET_POS = 3'd2,
    CMD_SET_IN  = 3'd3,
    CMD_SET_OUT = 3'd4,
    CMD_EVAL    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_SPAN,
    S_WGT,
    S_MAC,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    coord_t          px;
    coord_t          py;
    coord_t          pz;
    coord_t          tx;
    coord_t          ty;
    coord_t          tz;
    logic [CNT_W-1:0] count;
    status_e         status;
  } res_t;

  // Clamp a wide signed value into the coordinate range
  function automatic coord_t sat_c(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  // Round half up by the fraction width, then saturate
  function automatic coord_t round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = (v + ACC_W'(ONE / 2)) >>> FRAC;
    return sat_c(r);
  endfunction

endpackage

`default_nettype wire

@@ src/cbse_ram.sv @@
// ----------------------------------------------------------------------------
// cbse_ram: simple dual-port RAM with lane write enables
// One write port with a write enable per lane, one read port; read data is
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cbse_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 288,
  parameter int LANES = 3
) (
  input  logic                     clk,
  input  logic [LANES-1:0]         we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  localparam int LW = WIDTH / LANES;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, one enable per lane
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (we[l]) begin
        mem[waddr][l*LW +: LW] <= wdata[l*LW +: LW];
      end
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/cubic_bezier_spline_evaluator.sv @@
// ----------------------------------------------------------------------------
// cubic_bezier_spline_evaluator: piecewise cubic Bezier over a point table
// Keeps up to 64 control points (position, in-handle, out-handle) in one
// RAM, one entry per point with a write lane per part, edits them by command
// and evaluates a point and tangent on request.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_tvalid/tready   | in_tdata  (command, index, coords, t)
//   out_    | out | out_tvalid/tready  | out_tdata (point, tangent, count, status)
//
// An evaluate runs through accept, scale and span, the seven weight products
// on the shared weight multiplier, the eight multiply-accumulate steps of the
// per-axis lanes, rounding and hand-off; clear, append and set commands go
// from accept straight to hand-off.
// One item is in work at a time; a finished result waits in the output
// register while the next item is accepted.
// Reset (rst_n low, synchronous) empties the table; RAM contents stay.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_spline_evaluator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[2:0] index[8:3] pos_x pos_y pos_z in_x in_y in_z out_x out_y
  // out_z (32 bits each from bit 9) eval_t[314:297], zero fill to 320
  input  logic [319:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_x point_y point_z tangent_x tangent_y tangent_z (32 bits each)
  // point_count[198:192] status[200:199], zero fill to 208
  output logic [207:0] out_tdata
);

  localparam int CW = cbse_pkg::COORD_W;
  localparam int AW = cbse_pkg::ADDR_W;
  localparam int NW = cbse_pkg::CNT_W;
  localparam int VW = cbse_pkg::VEC_W;
  localparam int EW = 3 * cbse_pkg::VEC_W;

  // Input fields
  cbse_pkg::cmd_e        cmd;
  logic [AW-1:0]         idx;
  cbse_pkg::coord_t      f_pos [3];
  cbse_pkg::coord_t      f_in  [3];
  cbse_pkg::coord_t      f_out [3];
  logic signed [17:0]    f_t;

  always_comb begin
    cmd = cbse_pkg::cmd_e'(in_tdata[2:0]);
    idx = in_tdata[8:3];
    for (int k = 0; k < 3; k++) begin
      f_pos[k] = in_tdata[9 + k*CW +: CW];
      f_in[k]  = in_tdata[9 + (3+k)*CW +: CW];
      f_out[k] = in_tdata[9 + (6+k)*CW +: CW];
    end
    f_t = in_tdata[314:297];
  end

  // State
  cbse_pkg::state_e state_r, state_nxt;
  logic [2:0]       step_r;
  logic [NW-1:0]    cnt_r;
  cbse_pkg::res_t   res_r;
  cbse_pkg::res_t   out_r;
  logic             out_valid_r;

  logic [cbse_pkg::T_W-1:0]  tu_r, u_r, v_r;
  logic [cbse_pkg::SF_W-1:0] sf_r;
  logic [AW-1:0]             span_r;
  logic [32:0]               vv_r, uu_r, vu_r;
  logic [cbse_pkg::T_W-1:0]  bw_r [4];
  cbse_pkg::coord_t          c_r [4][3];
  logic signed [CW:0]        d_r [3][3];
  logic signed [cbse_pkg::PROD_W-1:0] prod_r [3];
  logic signed [cbse_pkg::ACC_W-1:0]  pacc_r [3];
  logic signed [cbse_pkg::ACC_W-1:0]  tacc_r [3];

  logic acc_in, load_out, full, idx_ok;

  assign acc_in   = in_tvalid && in_tready;
  assign full     = (cnt_r >= NW'(cbse_pkg::MAX_POINTS));
  assign idx_ok   = ({1'b0, idx} < cnt_r);
  assign load_out = (state_r == cbse_pkg::S_DONE) && (!out_valid_r || out_tready);

  // Status and count reported for a table edit
  cbse_pkg::status_e edit_stat;
  logic [NW-1:0]     edit_cnt;

  always_comb begin
    edit_stat = cbse_pkg::STAT_OK;
    edit_cnt  = cnt_r;
    if (cmd == cbse_pkg::CMD_CLEAR) begin
      edit_cnt = '0;
    end else if (cmd == cbse_pkg::CMD_APPEND) begin
      if (full) begin
        edit_stat = cbse_pkg::STAT_FULL;
      end else begin
        edit_cnt = cnt_r + NW'(1);
      end
    end else if (cmd inside {cbse_pkg::CMD_SET_POS, cbse_pkg::CMD_SET_IN,
                             cbse_pkg::CMD_SET_OUT} && !idx_ok) begin
      edit_stat = cbse_pkg::STAT_RANGE;
    end
  end

  // Append handles: an all-zero handle becomes position -/+ one unit in x
  logic [cbse_pkg::VEC_W-1:0] pos_vec, in_vec, out_vec, in_app, out_app;
  logic zin, zout;

  always_comb begin
    zin  = (f_in[0] == '0) && (f_in[1] == '0) && (f_in[2] == '0);
    zout = (f_out[0] == '0) && (f_out[1] == '0) && (f_out[2] == '0);
    pos_vec = {f_pos[2], f_pos[1], f_pos[0]};
    in_vec  = {f_in[2], f_in[1], f_in[0]};
    out_vec = {f_out[2], f_out[1], f_out[0]};
    in_app  = zin ? {f_pos[2], f_pos[1], cbse_pkg::sat_c(
                cbse_pkg::ACC_W'(f_pos[0]) - cbse_pkg::ACC_W'(cbse_pkg::ONE))} : in_vec;
    out_app = zout ? {f_pos[2], f_pos[1], cbse_pkg::sat_c(
                cbse_pkg::ACC_W'(f_pos[0]) + cbse_pkg::ACC_W'(cbse_pkg::ONE))} : out_vec;
  end

  // Span and local t from the scaled parameter
  logic [NW-1:0]             lim;
  logic [cbse_pkg::SF_W-cbse_pkg::FRAC-1:0] span_raw;
  logic [AW-1:0]             span_c;
  logic [cbse_pkg::SF_W-1:0] u_full;

  always_comb begin
    lim      = cnt_r - NW'(2);
    span_raw = sf_r[cbse_pkg::SF_W-1:cbse_pkg::FRAC];
    if (cnt_r < NW'(2)) begin
      span_c = '0;
    end else if (span_raw > (cbse_pkg::SF_W-cbse_pkg::FRAC)'(lim)) begin
      span_c = lim[AW-1:0];
    end else begin
      span_c = span_raw[AW-1:0];
    end
    u_full = sf_r - {(cbse_pkg::SF_W-AW-cbse_pkg::FRAC)'(0), span_c,
                     cbse_pkg::FRAC'(0)};
  end

  // Point table: lanes are position, in-handle, out-handle from the low end
  logic [2:0]    ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [EW-1:0] ram_wd, ram_rd;

  cbse_ram #(.DEPTH(cbse_pkg::MAX_POINTS), .WIDTH(EW), .LANES(3)) u_tab (
    .clk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra),
    .rdata(ram_rd));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cbse_pkg::S_IDLE:  if (acc_in) begin
        state_nxt = (cmd == cbse_pkg::CMD_EVAL) ? cbse_pkg::S_SCALE : cbse_pkg::S_DONE;
      end
      cbse_pkg::S_SCALE: state_nxt = cbse_pkg::S_SPAN;
      cbse_pkg::S_SPAN:  state_nxt = cbse_pkg::S_WGT;
      cbse_pkg::S_WGT:   if (step_r == 3'd6) state_nxt = cbse_pkg::S_MAC;
      cbse_pkg::S_MAC:   if (step_r == 3'd7) state_nxt = cbse_pkg::S_FIN;
      cbse_pkg::S_FIN:   state_nxt = cbse_pkg::S_DONE;
      cbse_pkg::S_DONE:  if (load_out) state_nxt = cbse_pkg::S_IDLE;
      default:           state_nxt = cbse_pkg::S_IDLE;
    endcase
  end

  // Handshake and memory control
  always_comb begin
    in_tready = (state_r == cbse_pkg::S_IDLE);
    ram_we[0] = acc_in && (((cmd == cbse_pkg::CMD_APPEND) && !full) ||
                           ((cmd == cbse_pkg::CMD_SET_POS) && idx_ok));
    ram_we[1] = acc_in && (((cmd == cbse_pkg::CMD_APPEND) && !full) ||
                           ((cmd == cbse_pkg::CMD_SET_IN) && idx_ok));
    ram_we[2] = acc_in && (((cmd == cbse_pkg::CMD_APPEND) && !full) ||
                           ((cmd == cbse_pkg::CMD_SET_OUT) && idx_ok));
    ram_wa    = (cmd == cbse_pkg::CMD_APPEND) ? cnt_r[AW-1:0] : idx;
    ram_wd    = {((cmd == cbse_pkg::CMD_APPEND) ? out_app : out_vec),
                 ((cmd == cbse_pkg::CMD_APPEND) ? in_app : in_vec),
                 pos_vec};
    // Read the span's first point, then the next one
    ram_ra    = (state_r == cbse_pkg::S_WGT) ? span_r + AW'(1) : span_c;
  end

  // Weight multiplier operands and rounded weights
  logic [32:0]               wa;
  logic [cbse_pkg::T_W-1:0]  wb;
  logic [49:0]               wp;
  logic [51:0]               wp_sc, wp_rnd;
  logic [35:0]               dw0_f, dw1_f, dw2_f;
  logic [cbse_pkg::WT_W-1:0] dw [3];

  always_comb begin
    case (step_r)
      3'd0:    begin wa = 33'(v_r); wb = v_r; end
      3'd1:    begin wa = 33'(u_r); wb = u_r; end
      3'd2:    begin wa = 33'(v_r); wb = u_r; end
      3'd3:    begin wa = vv_r;     wb = v_r; end
      3'd4:    begin wa = vv_r;     wb = u_r; end
      3'd5:    begin wa = uu_r;     wb = v_r; end
      default: begin wa = uu_r;     wb = u_r; end
    endcase
    wp     = 50'(wa) * 50'(wb);
    wp_sc  = ((step_r == 3'd4) || (step_r == 3'd5)) ? ({1'b0, wp, 1'b0} + 52'(wp))
                                                     : 52'(wp);
    wp_rnd = wp_sc + 52'(33'h080000000);
    dw0_f  = {3'b0, vv_r} + {2'b0, vv_r, 1'b0} + 36'd32768;
    dw1_f  = {1'b0, vu_r, 2'b0} + {2'b0, vu_r, 1'b0} + 36'd32768;
    dw2_f  = {3'b0, uu_r} + {2'b0, uu_r, 1'b0} + 36'd32768;
    dw[0]  = dw0_f[33:16];
    dw[1]  = dw1_f[33:16];
    dw[2]  = dw2_f[33:16];
  end

  // Lane multiplier operands
  logic signed [CW:0]                 mop [3];
  logic [cbse_pkg::WT_W-1:0]          mw;
  logic signed [cbse_pkg::PROD_W-1:0] mprod [3];

  always_comb begin
    case (step_r)
      3'd4:       mw = dw[0];
      3'd5:       mw = dw[1];
      3'd6, 3'd7: mw = dw[2];
      default:    mw = cbse_pkg::WT_W'(bw_r[step_r[1:0]]);
    endcase
    for (int k = 0; k < 3; k++) begin
      case (step_r)
        3'd0, 3'd1, 3'd2, 3'd3: mop[k] = (CW+1)'(c_r[step_r[1:0]][k]);
        3'd4:    mop[k] = d_r[0][k];
        3'd5:    mop[k] = d_r[1][k];
        default: mop[k] = d_r[2][k];
      endcase
      mprod[k] = mop[k] * $signed({1'b0, mw});
    end
  end

  // Sequencer state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbse_pkg::S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + 3'd1;
      end
      if (acc_in) begin
        if (cmd == cbse_pkg::CMD_CLEAR) begin
          cnt_r <= '0;
        end else if ((cmd == cbse_pkg::CMD_APPEND) && !full) begin
          cnt_r <= cnt_r + NW'(1);
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // Take the command and form the result of table edits
    if (acc_in) begin
      res_r.px     <= '0;
      res_r.py     <= '0;
      res_r.pz     <= '0;
      res_r.tx     <= '0;
      res_r.ty     <= '0;
      res_r.tz     <= '0;
      res_r.status <= edit_stat;
      res_r.count  <= edit_cnt;
      if (f_t < 18'sd0) begin
        tu_r <= '0;
      end else if (f_t > 18'sd65536) begin
        tu_r <= cbse_pkg::T_W'(cbse_pkg::ONE);
      end else begin
        tu_r <= f_t[cbse_pkg::T_W-1:0];
      end
    end

    // Scale t by count-1
    if (state_r == cbse_pkg::S_SCALE) begin
      sf_r <= cbse_pkg::SF_W'(tu_r) * cbse_pkg::SF_W'(cnt_r - NW'(1));
    end

    // Pick span and local t
    if (state_r == cbse_pkg::S_SPAN) begin
      span_r <= span_c;
      u_r    <= u_full[cbse_pkg::T_W-1:0];
      v_r    <= cbse_pkg::T_W'(cbse_pkg::ONE) - u_full[cbse_pkg::T_W-1:0];
    end

    // Weights, control point capture and differences
    if (state_r == cbse_pkg::S_WGT) begin
      case (step_r)
        3'd0:    vv_r <= wp[32:0];
        3'd1:    uu_r <= wp[32:0];
        3'd2:    vu_r <= wp[32:0];
        3'd3:    bw_r[0] <= wp_rnd[48:32];
        3'd4:    bw_r[1] <= wp_rnd[48:32];
        3'd5:    bw_r[2] <= wp_rnd[48:32];
        default: bw_r[3] <= wp_rnd[48:32];
      endcase
      for (int k = 0; k < 3; k++) begin
        if (step_r == 3'd0) begin
          c_r[0][k] <= ram_rd[k*CW +: CW];
          c_r[1][k] <= ram_rd[2*VW + k*CW +: CW];
        end
        if (step_r == 3'd1) begin
          c_r[2][k] <= ram_rd[VW + k*CW +: CW];
          c_r[3][k] <= ram_rd[k*CW +: CW];
        end
        if (step_r == 3'd2) begin
          d_r[0][k] <= (CW+1)'(c_r[1][k]) - (CW+1)'(c_r[0][k]);
          d_r[1][k] <= (CW+1)'(c_r[2][k]) - (CW+1)'(c_r[1][k]);
          d_r[2][k] <= (CW+1)'(c_r[3][k]) - (CW+1)'(c_r[2][k]);
        end
        pacc_r[k] <= '0;
        tacc_r[k] <= '0;
      end
    end

    // Multiply and accumulate, one term per step on each axis
    if (state_r == cbse_pkg::S_MAC) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= mprod[k];
        if (step_r != 3'd0) begin
          if (step_r <= 3'd4) begin
            pacc_r[k] <= pacc_r[k] + cbse_pkg::ACC_W'(prod_r[k]);
          end else begin
            tacc_r[k] <= tacc_r[k] + cbse_pkg::ACC_W'(prod_r[k]);
          end
        end
      end
    end

    // Round, saturate and handle short tables
    if (state_r == cbse_pkg::S_FIN) begin
      if (cnt_r < NW'(2)) begin
        res_r.px <= (cnt_r == NW'(1)) ? c_r[0][0] : '0;
        res_r.py <= (cnt_r == NW'(1)) ? c_r[0][1] : '0;
        res_r.pz <= (cnt_r == NW'(1)) ? c_r[0][2] : '0;
        res_r.tx <= '0;
        res_r.ty <= '0;
        res_r.tz <= cbse_pkg::sat_c(cbse_pkg::ACC_W'(cbse_pkg::ONE));
      end else begin
        res_r.px <= cbse_pkg::round_sat(pacc_r[0]);
        res_r.py <= cbse_pkg::round_sat(pacc_r[1]);
        res_r.pz <= cbse_pkg::round_sat(pacc_r[2]);
        res_r.tx <= cbse_pkg::round_sat(tacc_r[0]);
        res_r.ty <= cbse_pkg::round_sat(tacc_r[1]);
        res_r.tz <= cbse_pkg::round_sat(tacc_r[2]);
      end
    end

    // Hand the result to the output register
    if (load_out) begin
      out_r <= res_r;
    end
  end

  // Output channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.status, out_r.count, out_r.tz, out_r.ty, out_r.tx,
                       out_r.pz, out_r.py, out_r.px};

endmodule

`default_nettype wire

@@ src/cbse_checker.sv @@
// ----------------------------------------------------------------------------
// cbse_checker: port-level checks for the spline evaluator
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbse_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [207:0] out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Take one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  // Report only defined status codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[200:199] != 2'd3)
    else $error("undefined status");

  // Keep the count within the table
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[198:192] <= 7'd64)
    else $error("point count beyond table");

  // Flag a full table only at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[200:199] == 2'd2 |-> out_tdata[198:192] == 7'd64)
    else $error("full status below capacity");

endmodule

bind cubic_bezier_spline_evaluator cbse_checker u_cbse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire
